/* hw/rtl/csvti_pkg.sv */
`timescale 1ns / 1ps

package csvti_pkg;

   // Operation carried by each input item.
   typedef enum logic [1:0] {
      OP_CHAR       = 2'd0,
      OP_END_CELL   = 2'd1,
      OP_END_COLUMN = 2'd2,
      OP_UNUSED     = 2'd3
   } op_code_type;

   // Cell and column type codes, listed in priority order.
   typedef enum logic [1:0] {
      TYPE_BOOL   = 2'd0,
      TYPE_FLOAT  = 2'd1,
      TYPE_INT    = 2'd2,
      TYPE_STRING = 2'd3
   } type_code_type;

   typedef struct packed {
      op_code_type op;
      logic [7:0]  ch;
   } req_payload_type;

   typedef struct packed {
      type_code_type cell_type;
      type_code_type column_type;
      logic          column_done;
   } rsp_payload_type;

   // Per-cycle control decoded from the item that is being processed.
   typedef struct packed {
      logic take_char;
      logic end_cell;
      logic end_column;
   } step_type;

   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [2:0] TRUE_LENGTH  = 3'd4;
   localparam logic [2:0] FALSE_LENGTH = 3'd5;
   localparam logic [2:0] POSITION_MAX = 3'd7;

   // Letters of "true", indexed by character position.
   function automatic logic [7:0] true_letter(input logic [1:0] pos);
      logic [7:0] letter;
      case (pos)
         2'd0:    letter = 8'h74;
         2'd1:    letter = 8'h72;
         2'd2:    letter = 8'h75;
         default: letter = 8'h65;
      endcase
      return letter;
   endfunction

   // Letters of "false", indexed by character position.
   function automatic logic [7:0] false_letter(input logic [2:0] pos);
      logic [7:0] letter;
      case (pos)
         3'd0:    letter = 8'h66;
         3'd1:    letter = 8'h61;
         3'd2:    letter = 8'h6C;
         3'd3:    letter = 8'h73;
         3'd4:    letter = 8'h65;
         default: letter = 8'h00;
      endcase
      return letter;
   endfunction

endpackage

/* hw/rtl/csvti_cell.sv */
`timescale 1ns / 1ps

module csvti_cell import csvti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  step_type      step,
   input  logic [7:0]    ch,
   input  logic          allow_leading_dot,
   output type_code_type cell_type
);

   logic [2:0] pos_ff, pos_in;
   logic       true_ff, true_in;
   logic       false_ff, false_in;
   logic       sign_ff, sign_in;
   logic       start_ok_ff, start_ok_in;
   logic       open_ff, open_in;
   logic [1:0] dots_ff, dots_in;
   logic       int_ok_ff, int_ok_in;

   logic [7:0] lower_ch;
   logic       is_digit;
   logic       body_start;

   // Character classification.
   assign lower_ch = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ? ch + CASE_OFFSET : ch;
   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   // The first character after an optional leading minus.
   assign body_start = sign_ff ? (pos_ff == 3'd1) : (pos_ff == 3'd0);

   // Next state of the cell flags.
   always_comb begin
      pos_in      = pos_ff;
      true_in     = true_ff;
      false_in    = false_ff;
      sign_in     = sign_ff;
      start_ok_in = start_ok_ff;
      open_in     = open_ff;
      dots_in     = dots_ff;
      int_ok_in   = int_ok_ff;
      if (step.end_cell) begin
         pos_in      = '0;
         true_in     = 1'b1;
         false_in    = 1'b1;
         sign_in     = 1'b0;
         start_ok_in = 1'b0;
         open_in     = 1'b1;
         dots_in     = '0;
         int_ok_in   = 1'b1;
      end else if (step.take_char) begin
         if (pos_ff >= TRUE_LENGTH || lower_ch != true_letter(pos_ff[1:0])) begin
            true_in = 1'b0;
         end
         if (pos_ff >= FALSE_LENGTH || lower_ch != false_letter(pos_ff)) begin
            false_in = 1'b0;
         end
         if (pos_ff == 3'd0 && ch == CHAR_DASH) begin
            sign_in = 1'b1;
         end else begin
            if (!is_digit) begin
               int_ok_in = 1'b0;
            end
            if (body_start && !allow_leading_dot) begin
               start_ok_in = is_digit;
               if (!is_digit) begin
                  open_in = 1'b0;
               end
            end else if (open_ff) begin
               if (ch == CHAR_DOT) begin
                  if (dots_ff != 2'd2) begin
                     dots_in = dots_ff + 2'd1;
                  end
               end else if (!is_digit) begin
                  open_in = 1'b0;
               end
            end
         end
         if (pos_ff != POSITION_MAX) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         true_ff     <= 1'b1;
         false_ff    <= 1'b1;
         sign_ff     <= 1'b0;
         start_ok_ff <= 1'b0;
         open_ff     <= 1'b1;
         dots_ff     <= '0;
         int_ok_ff   <= 1'b1;
      end else begin
         pos_ff      <= pos_in;
         true_ff     <= true_in;
         false_ff    <= false_in;
         sign_ff     <= sign_in;
         start_ok_ff <= start_ok_in;
         open_ff     <= open_in;
         dots_ff     <= dots_in;
         int_ok_ff   <= int_ok_in;
      end
   end

   // Classification of the cell seen so far, in priority order.
   always_comb begin
      if ((true_ff && pos_ff == TRUE_LENGTH) || (false_ff && pos_ff == FALSE_LENGTH)) begin
         cell_type = TYPE_BOOL;
      end else if ((allow_leading_dot || start_ok_ff) && dots_ff == 2'd1) begin
         cell_type = TYPE_FLOAT;
      end else if (int_ok_ff) begin
         cell_type = TYPE_INT;
      end else begin
         cell_type = TYPE_STRING;
      end
   end

`ifndef SYNTHESIS
   // The minus sign is only ever recorded as the first character.
   assert property (@(posedge clock) disable iff (reset)
      sign_ff |-> (pos_ff != 3'd0))
      else $error("sign flag set with no character seen");

   // A finished cell leaves all flags at their starting values.
   assert property (@(posedge clock) disable iff (reset)
      step.end_cell |=> (pos_ff == 3'd0 && dots_ff == 2'd0 && int_ok_ff && open_ff))
      else $error("cell state not cleared after end of cell");
`endif

endmodule

/* hw/rtl/csvti_column.sv */
`timescale 1ns / 1ps

module csvti_column import csvti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  step_type      step,
   input  type_code_type cell_type,
   output type_code_type column_type
);

   type_code_type run_ff, run_in;
   logic          has_cell_ff, has_cell_in;

   // Column type including the cell that ends now.
   always_comb begin
      if (!has_cell_ff) begin
         column_type = cell_type;
      end else if (cell_type != run_ff) begin
         column_type = TYPE_STRING;
      end else begin
         column_type = run_ff;
      end
   end

   always_comb begin
      run_in      = run_ff;
      has_cell_in = has_cell_ff;
      if (step.end_column) begin
         run_in      = TYPE_BOOL;
         has_cell_in = 1'b0;
      end else if (step.end_cell) begin
         run_in      = column_type;
         has_cell_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= TYPE_BOOL;
         has_cell_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         has_cell_ff <= has_cell_in;
      end
   end

`ifndef SYNTHESIS
   // Ending a column starts the next one empty.
   assert property (@(posedge clock) disable iff (reset)
      step.end_column |=> !has_cell_ff)
      else $error("column state not cleared after end of column");
`endif

endmodule

/* hw/rtl/csv_column_type_inference_top.sv */
`timescale 1ns / 1ps

// CSV column type inference.
// The req channel carries one item per cycle: a cell character (op char) or
// an end-of-cell marker, which may also end the column. Unused op codes are
// dropped. The rsp channel returns one item per finished cell: the cell's
// type, the column type so far and a flag marking the column's last cell.
// Types are coded bool, float, int, string, in that priority order.
// The csr channel writes the allow-leading-dot bit; csr_ready is always high
// and the bit should only change while the block is idle.
// An accepted item is processed from the input register; an end-of-cell
// item writes its result into the result register as it is processed. One
// item per cycle is taken unless an end-of-cell item waits; the cell flags
// and the column type are updated between the input and result registers.
// When rsp_stall holds a result, character items keep flowing; only an
// end-of-cell item waits in the input register, with req_stall high, until
// the result slot frees. Reset (synchronous, active high) empties both
// registers, clears the cell and column state and clears the csr bit.
module csv_column_type_inference_top import csvti_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_payload_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   logic            allow_dot_ff;

   logic            is_end;
   logic            out_free;
   logic            process;
   logic            req_take;
   step_type        step;
   type_code_type   cell_type;
   type_code_type   column_type;

   // Handshake decisions for the input register.
   assign is_end    = (in_payload_ff.op == OP_END_CELL) || (in_payload_ff.op == OP_END_COLUMN);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && (!is_end || out_free);
   assign req_stall = in_valid_ff && !process;
   assign req_take  = req_valid && !req_stall;

   assign step.take_char  = process && (in_payload_ff.op == OP_CHAR);
   assign step.end_cell   = process && is_end;
   assign step.end_column = process && (in_payload_ff.op == OP_END_COLUMN);

   assign in_valid_in  = req_take || (in_valid_ff && !process);
   assign rsp_valid_in = step.end_cell || (rsp_valid_ff && rsp_stall);

   csvti_cell u_cell (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .ch                (in_payload_ff.ch),
      .allow_leading_dot (allow_dot_ff),
      .cell_type         (cell_type)
   );

   csvti_column u_column (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cell_type   (cell_type),
      .column_type (column_type)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_payload_ff <= req_payload;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step.end_cell) begin
         rsp_payload_ff.cell_type   <= cell_type;
         rsp_payload_ff.column_type <= column_type;
         rsp_payload_ff.column_done <= step.end_column;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_dot_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         allow_dot_ff <= csr_data;
      end
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // Every processed end of cell yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      step.end_cell |=> rsp_valid)
      else $error("end of cell produced no result");

   // A waiting result is never overwritten by a new one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !step.end_cell)
      else $error("result overwritten while stalled");

   // The column type is either this cell's type or string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.column_type == rsp_payload.cell_type ||
                     rsp_payload.column_type == TYPE_STRING))
      else $error("column type inconsistent with cell type");
`endif

endmodule

/* sim/csvti_type_checker.sv */
`timescale 1ns / 1ps

// Watches the req, rsp and csr channels of the column type inference block.
// Every accepted req item is run through a local copy of the cell and column
// classifier; each end-of-cell item queues the result item the block owes.
// Every accepted rsp item is compared field by field with the oldest one.
module csvti_type_checker import csvti_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic            csr_data,
   output int              mismatch_count,
   output int              results_owed
);

   localparam logic [31:0] WORD_TRUE  = "true";
   localparam logic [39:0] WORD_FALSE = "false";

   // Mirror of the block's csr bit and of its cell and column state.
   logic            leading_dot_ok;
   logic [2:0]      char_count;
   logic            true_alive;
   logic            false_alive;
   logic            sign_seen;
   logic            start_digit_seen;
   logic            prefix_open;
   logic [1:0]      dot_total;
   logic            int_alive;
   type_code_type   column_so_far;
   logic            column_started;
   rsp_payload_type owed_types[$];

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   task automatic clear_cell();
      char_count       = 3'd0;
      true_alive       = 1'b1;
      false_alive      = 1'b1;
      sign_seen        = 1'b0;
      start_digit_seen = 1'b0;
      prefix_open      = 1'b1;
      dot_total        = 2'd0;
      int_alive        = 1'b1;
   endtask

   // Folds one cell character into the running flags.
   task automatic absorb_char(input logic [7:0] c);
      logic [7:0] lower;
      logic [2:0] body;
      logic [2:0] false_index;
      lower = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
      false_index = (char_count < 3'd5) ? char_count : 3'd0;
      if (char_count >= 3'd4 || lower != WORD_TRUE[8 * (3 - char_count[1:0]) +: 8]) begin
         true_alive = 1'b0;
      end
      if (char_count >= 3'd5 || lower != WORD_FALSE[8 * (4 - false_index) +: 8]) begin
         false_alive = 1'b0;
      end
      // A leading minus is skipped by the number rules.
      if (char_count == 3'd0 && c == CHAR_DASH) begin
         sign_seen = 1'b1;
      end else begin
         body = char_count - {2'b00, sign_seen};
         if (!is_digit(c)) begin
            int_alive = 1'b0;
         end
         if (body == 3'd0 && !leading_dot_ok) begin
            start_digit_seen = is_digit(c);
            if (!start_digit_seen) begin
               prefix_open = 1'b0;
            end
         end else if (prefix_open) begin
            if (c == CHAR_DOT) begin
               if (dot_total < 2'd2) begin
                  dot_total++;
               end
            end else if (!is_digit(c)) begin
               prefix_open = 1'b0;
            end
         end
      end
      if (char_count < POSITION_MAX) begin
         char_count++;
      end
   endtask

   // Type of the finished cell, in priority order.
   function automatic type_code_type classify_cell();
      if ((true_alive && char_count == TRUE_LENGTH) ||
          (false_alive && char_count == FALSE_LENGTH)) begin
         return TYPE_BOOL;
      end
      if ((leading_dot_ok || start_digit_seen) && dot_total == 2'd1) begin
         return TYPE_FLOAT;
      end
      if (int_alive) begin
         return TYPE_INT;
      end
      return TYPE_STRING;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      type_code_type   finished;
      if (reset) begin
         clear_cell();
         leading_dot_ok = 1'b0;
         column_so_far  = TYPE_BOOL;
         column_started = 1'b0;
         owed_types.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            leading_dot_ok = csr_data;
         end

         // Predict from the accepted req item.
         if (req_valid && !req_stall) begin
            case (req_payload.op)
               OP_CHAR: begin
                  absorb_char(req_payload.ch);
               end
               OP_END_CELL, OP_END_COLUMN: begin
                  finished = classify_cell();
                  if (!column_started) begin
                     column_so_far  = finished;
                     column_started = 1'b1;
                  end else if (finished != column_so_far) begin
                     column_so_far = TYPE_STRING;
                  end
                  want.cell_type   = finished;
                  want.column_type = column_so_far;
                  want.column_done = (req_payload.op == OP_END_COLUMN);
                  owed_types.push_back(want);
                  clear_cell();
                  if (req_payload.op == OP_END_COLUMN) begin
                     column_so_far  = TYPE_BOOL;
                     column_started = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end

         // Compare the accepted rsp item with the oldest owed one.
         if (rsp_valid && !rsp_stall) begin
            if (owed_types.size() == 0) begin
               $display("%0t: result item with none owed: expected nothing, got %h",
                        $time, rsp_payload);
               mismatch_count++;
            end else begin
               want = owed_types.pop_front();
               if (rsp_payload.cell_type !== want.cell_type) begin
                  $display("%0t: cell_type expected %0d, got %0d",
                           $time, want.cell_type, rsp_payload.cell_type);
                  mismatch_count++;
               end
               if (rsp_payload.column_type !== want.column_type) begin
                  $display("%0t: column_type expected %0d, got %0d",
                           $time, want.column_type, rsp_payload.column_type);
                  mismatch_count++;
               end
               if (rsp_payload.column_done !== want.column_done) begin
                  $display("%0t: column_done expected %0d, got %0d",
                           $time, want.column_done, rsp_payload.column_done);
                  mismatch_count++;
               end
            end
         end
      end
      results_owed = owed_types.size();
   end

endmodule

/* sim/tb_csv_column_type_inference_top.sv */
`timescale 1ns / 1ps

module tb_csv_column_type_inference_top;
   import csvti_pkg::*;

   localparam int HOLD_CYCLES = 250;
   localparam int STALL_LIMIT = 2000;

   typedef enum int {
      SHAPE_BOOL,
      SHAPE_FLOAT,
      SHAPE_INT,
      SHAPE_TEXT
   } cell_shape_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic            csr_data;
   int              mismatch_count;
   int              results_owed;

   bit              quiet_mode;
   bit              sender_gaps;
   int              hold_requests;
   int              items_sent;
   logic [7:0]      cell_text[$];

   csv_column_type_inference_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   csvti_type_checker type_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offers one item, optionally after an idle burst, and holds it until taken.
   // Called and returns at a falling edge.
   task automatic offer(input op_code_type op, input logic [7:0] ch);
      if (!quiet_mode && sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_payload <= {op, ch};
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (op != OP_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic offer_text(input string text, input op_code_type ending);
      for (int i = 0; i < text.len(); i++) begin
         offer(OP_CHAR, text[i]);
      end
      offer(ending, 8'hFF);
   endtask

   // Waits until every owed result item has come back and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_leading_dot(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] any_case(input logic [7:0] letter);
      return ($urandom_range(0, 1) != 0) ? letter - CASE_OFFSET : letter;
   endfunction

   function automatic logic [7:0] some_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Builds the characters of one cell of the given shape into cell_text.
   function automatic void build_cell(input cell_shape_type shape);
      string word;
      string pool;
      int    count;
      pool = "-.09/:Ee";
      cell_text.delete();
      case (shape)
         SHAPE_BOOL: begin
            word = ($urandom_range(0, 1) != 0) ? "true" : "false";
            for (int i = 0; i < word.len(); i++) begin
               cell_text.push_back(any_case(word[i]));
            end
            // Now and then spoil the word by a character too many or too few.
            if ($urandom_range(0, 9) == 0) begin
               cell_text.push_back(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 9) == 0) begin
               void'(cell_text.pop_back());
            end
         end
         SHAPE_FLOAT: begin
            if ($urandom_range(0, 2) == 0) begin
               cell_text.push_back(CHAR_DASH);
            end
            if ($urandom_range(0, 4) != 0) begin
               cell_text.push_back(some_digit());
            end
            count = $urandom_range(0, 3);
            repeat (count) cell_text.push_back(some_digit());
            cell_text.push_back(CHAR_DOT);
            count = $urandom_range(0, 3);
            repeat (count) cell_text.push_back(some_digit());
            if ($urandom_range(0, 7) == 0) begin
               cell_text.push_back(CHAR_DOT);
            end
            if ($urandom_range(0, 5) == 0) begin
               cell_text.push_back(8'($urandom_range(0, 255)));
            end
         end
         SHAPE_INT: begin
            if ($urandom_range(0, 2) == 0) begin
               cell_text.push_back(CHAR_DASH);
            end
            count = $urandom_range(0, 7);
            repeat (count) cell_text.push_back(some_digit());
         end
         default: begin
            count = $urandom_range(1, 9);
            repeat (count) begin
               if ($urandom_range(0, 3) == 0) begin
                  cell_text.push_back(pool[$urandom_range(0, 7)]);
               end else begin
                  cell_text.push_back(8'($urandom_range(0, 255)));
               end
            end
         end
      endcase
   endfunction

   // Sends one column: cells mostly of one shape, with a little noise mixed in.
   task automatic offer_column(input bit gaps_allowed);
      cell_shape_type main_shape;
      cell_shape_type shape;
      int             cells;
      main_shape  = cell_shape_type'($urandom_range(0, 3));
      cells       = $urandom_range(1, 6);
      sender_gaps = gaps_allowed && ($urandom_range(0, 2) != 0);
      for (int k = 0; k < cells; k++) begin
         shape = ($urandom_range(0, 4) == 0) ? cell_shape_type'($urandom_range(0, 3))
                                             : main_shape;
         build_cell(shape);
         foreach (cell_text[j]) begin
            offer(OP_CHAR, cell_text[j]);
         end
         if ($urandom_range(0, 19) == 0) begin
            offer(op_code_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
         offer((k == cells - 1) ? OP_END_COLUMN : OP_END_CELL, 8'($urandom_range(0, 255)));
      end
   endtask

   // Result side: random stall bursts, with one long hold on request.
   initial begin : receiver
      int holds_served;
      bit stall_bursts;
      holds_served = 0;
      stall_bursts = 1'b1;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_mode && stall_bursts && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 63) == 0) begin
            stall_bursts = !stall_bursts;
         end
      end
   end

   // Ends the run when no channel moves an item for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int target;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_valid     = 1'b0;
      csr_data      = 1'b0;
      quiet_mode    = 1'b0;
      sender_gaps   = 1'b0;
      hold_requests = 0;
      items_sent    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed cells with the leading digit required.
      set_leading_dot(1'b0);
      sender_gaps = 1'b1;
      offer_text("TRUE", OP_END_CELL);
      offer_text("fAlSe", OP_END_COLUMN);
      // A lone minus with an unused op in the middle, then an empty cell.
      offer(OP_CHAR, CHAR_DASH);
      offer(OP_UNUSED, 8'hFF);
      offer(OP_END_CELL, 8'h00);
      offer(OP_END_COLUMN, 8'h01);
      // Float with trailing junk, a zero byte, and a cell past the bool length.
      offer(OP_CHAR, CHAR_DASH);
      offer(OP_CHAR, 8'h33);
      offer(OP_CHAR, CHAR_DOT);
      offer(OP_CHAR, 8'h37);
      offer(OP_CHAR, 8'h00);
      offer(OP_CHAR, 8'h01);
      offer(OP_END_COLUMN, 8'hFF);

      // Directed cells with leading dots allowed.
      settle();
      set_leading_dot(1'b1);
      offer_text(".5", OP_END_CELL);
      offer_text("-.25.", OP_END_CELL);
      offer_text(".", OP_END_COLUMN);

      // Random columns over several settings; one long receiver hold in the
      // third phase and no idling at all in the last one.
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         set_leading_dot(phase[0]);
         quiet_mode <= (phase == 3);
         if (phase == 2) begin
            hold_requests <= hold_requests + 1;
         end
         target = items_sent + 100;
         while (items_sent < target) begin
            offer_column(phase != 3 && !(phase == 2 && items_sent < target - 70));
         end
      end

      settle();
      repeat (6) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
